// File: src/pll_refcount_arbiter_unit_assert.svh
// ----------------------------------------------------------------------------
// PLL reference-count arbiter assertion macros
// Shared property forms for the arbiter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PLL_REFCOUNT_ARBITER_UNIT_ASSERT_SVH
`define PLL_REFCOUNT_ARBITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pra_pkg.sv
// ----------------------------------------------------------------------------
// PLL reference-count arbiter package
// Request and result types, opcodes, status codes and control structs.
// ----------------------------------------------------------------------------
package pra_pkg;

    // Opcodes
    localparam logic [2:0] OP_PLL_REQ   = 3'd0;
    localparam logic [2:0] OP_PLL_REL   = 3'd1;
    localparam logic [2:0] OP_MIC_REQ   = 3'd2;
    localparam logic [2:0] OP_MIC_REL   = 3'd3;
    localparam logic [2:0] OP_MIC_FORCE = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_ZERO      = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Register indexes (paddr[2])
    localparam logic REG_SWITCH_MODE = 1'b0;
    localparam logic REG_PLL_COUNT   = 1'b1;

    localparam logic [1:0] PLL_COUNT_RESET = 2'd3;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] pll_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] current_pll;
        logic       switched;
        logic [1:0] switch_from;
        logic [1:0] switch_to;
        logic [2:0] pll_on_mask;
        logic       supply_on;
        logic       ibias_on;
        logic       micbias_on;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } dp_stat_t;

endpackage

// File: src/pll_refcount_arbiter_unit.sv
// ----------------------------------------------------------------------------
// PLL reference-count arbiter
// Per-PLL use counts with current-PLL selection and shared power counts.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  request   in         start && !busy                request (in_item_t)
//  result    out        done, one cycle, no stall     result (out_item_t)
//  config    in         psel && penable && pwrite     paddr, pwdata / prdata
//
//  A request is loaded on acceptance, executed in S_EXEC and reported in
//  S_FINISH; when the current PLL loses its last user, S_SCAN comes between
//  and the fallback search walks the lower PLL counts one per cycle.
//  The next start is taken once the unit is back in S_IDLE.
//  Reset clears all counts, selects no PLL and sets pll_count to 3.
//  The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module pll_refcount_arbiter_unit #(
    parameter int PLL_SLOTS  = 3,
    parameter int COUNT_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pra_pkg::in_item_t  request,
    output logic               done,
    output pra_pkg::out_item_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pra_pkg::*;

    logic       mode_reg;
    logic [1:0] count_reg;
    logic       cfg_wr;
    ctl_cmd_t   cmd;
    dp_stat_t   stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= PLL_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SWITCH_MODE: mode_reg  <= pwdata[0];
                REG_PLL_COUNT:   count_reg <= pwdata[1:0];
                default:         mode_reg  <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SWITCH_MODE: prdata = {31'b0, mode_reg};
            REG_PLL_COUNT:   prdata = {30'b0, count_reg};
            default:         prdata = '0;
        endcase
    end

    pra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pra_datapath #(
        .PLL_SLOTS  (PLL_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .request     (request),
        .switch_mode (mode_reg),
        .pll_count   (count_reg),
        .result      (result)
    );

endmodule

// File: src/pra_ctrl.sv
// ----------------------------------------------------------------------------
// PLL reference-count arbiter controller
// Sequences load, execute, fallback scan when needed, and report for each request.
// ----------------------------------------------------------------------------
module pra_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  pra_pkg::dp_stat_t stat,
    output pra_pkg::ctl_cmd_t cmd,
    output logic             busy,
    output logic             done
);
    import pra_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.need_scan ? S_SCAN : S_FINISH;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_FINISH);
    assign cmd.load = (state_reg == S_IDLE) && start;
    assign cmd.exec = (state_reg == S_EXEC);
    assign cmd.scan = (state_reg == S_SCAN);

`include "pll_refcount_arbiter_unit_assert.svh"

    `PRA_ASSERT_NEXT(a_load_then_exec, cmd.load, cmd.exec, "accepted request not executed")
    `PRA_ASSERT_NEXT(a_exec_no_scan_done, cmd.exec && !stat.need_scan, done, "missing report")
    `PRA_ASSERT_NEXT(a_done_then_idle, done, !busy && !done, "result strobe not single")

endmodule

// File: src/pra_datapath.sv
// ----------------------------------------------------------------------------
// PLL reference-count arbiter datapath
// Use counts, current PLL, mic count, shared supply and bias counts, result fields.
// ----------------------------------------------------------------------------
module pra_datapath #(
    parameter int PLL_SLOTS  = 3,
    parameter int COUNT_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pra_pkg::ctl_cmd_t  cmd,
    output pra_pkg::dp_stat_t  stat,
    input  pra_pkg::in_item_t  request,
    input  logic              switch_mode,
    input  logic [1:0]        pll_count,
    output pra_pkg::out_item_t result
);
    import pra_pkg::*;

    localparam int SW = (PLL_SLOTS > 1) ? $clog2(PLL_SLOTS) : 1;
    localparam int AW = $clog2(PLL_SLOTS + 1);
    localparam logic [SW-1:0] TOP = SW'(PLL_SLOTS - 1);
    localparam logic [2:0] SLOT_LIMIT = 3'(PLL_SLOTS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0] users_reg [PLL_SLOTS];
    logic [COUNT_BITS-1:0] users_next [PLL_SLOTS];
    logic [AW-1:0]         active_reg, active_next;
    logic [COUNT_BITS-1:0] supply_reg, supply_next;
    logic [COUNT_BITS-1:0] bias_reg, bias_next;
    logic [COUNT_BITS-1:0] mic_reg, mic_next;
    logic [2:0]            op_reg, op_next;
    logic [2:0]            idx_reg, idx_next;
    logic [AW-1:0]         before_reg, before_next;
    logic [1:0]            status_reg, status_next;
    logic [SW-1:0]         scan_ptr_reg, scan_ptr_next;

    logic                  idx_ok;
    logic [SW-1:0]         slot;
    logic [AW-1:0]         slot_p1;
    logic [SW-1:0]         rd_addr;
    logic [COUNT_BITS-1:0] cur;
    logic                  top_sel;
    logic                  need_scan;
    logic                  pwr_up, pwr_dn, mic_bias_up, mic_bias_dn;
    logic [2:0]            mask;

    assign idx_ok  = (idx_reg < {1'b0, pll_count}) && (idx_reg < SLOT_LIMIT);
    assign slot    = idx_reg[SW-1:0];
    assign slot_p1 = AW'(slot) + AW'(1);
    assign rd_addr = cmd.scan ? (scan_ptr_reg - SW'(1)) : slot;
    assign cur     = users_reg[rd_addr];
    assign top_sel = switch_mode && (slot == TOP);

    assign stat.need_scan = need_scan;
    assign stat.scan_done = (scan_ptr_reg == '0) || (cur != '0);

    always_comb
    begin
        users_next    = users_reg;
        active_next   = active_reg;
        supply_next   = supply_reg;
        bias_next     = bias_reg;
        mic_next      = mic_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        before_next   = before_reg;
        status_next   = status_reg;
        scan_ptr_next = scan_ptr_reg;
        need_scan     = 1'b0;
        pwr_up        = 1'b0;
        pwr_dn        = 1'b0;
        mic_bias_up   = 1'b0;
        mic_bias_dn   = 1'b0;

        if (cmd.load)
        begin
            op_next     = request.opcode;
            idx_next    = request.pll_index;
            before_next = active_reg;
        end

        if (cmd.exec)
        begin
            status_next = ST_OK;
            unique case (op_reg)
                OP_PLL_REQ:
                begin
                    if (!idx_ok)
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                    else if (cur == CNT_MAX)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        users_next[slot] = cur + CNT_ONE;
                        if (cur == '0)
                        begin
                            if (top_sel)
                            begin
                                pwr_up = 1'b1;
                            end
                            else if (slot_p1 > active_reg)
                            begin
                                pwr_up      = (active_reg == '0);
                                active_next = slot_p1;
                            end
                        end
                    end
                end
                OP_PLL_REL:
                begin
                    if (!idx_ok)
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                    else if (cur == '0)
                    begin
                        status_next = ST_ZERO;
                    end
                    else
                    begin
                        users_next[slot] = cur - CNT_ONE;
                        if (cur == CNT_ONE)
                        begin
                            if (top_sel)
                            begin
                                pwr_dn = 1'b1;
                            end
                            else if (slot_p1 == active_reg)
                            begin
                                // current PLL lost its last user: look below it
                                need_scan     = 1'b1;
                                scan_ptr_next = slot;
                            end
                        end
                    end
                end
                OP_MIC_REQ:
                begin
                    if (mic_reg == CNT_MAX)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mic_next    = mic_reg + CNT_ONE;
                        mic_bias_up = (mic_reg == '0);
                    end
                end
                OP_MIC_REL:
                begin
                    if (mic_reg == '0)
                    begin
                        status_next = ST_ZERO;
                    end
                    else
                    begin
                        mic_next    = mic_reg - CNT_ONE;
                        mic_bias_dn = (mic_reg == CNT_ONE);
                    end
                end
                OP_MIC_FORCE:
                begin
                    if (mic_reg == '0)
                    begin
                        status_next = ST_ZERO;
                    end
                    else
                    begin
                        mic_next    = '0;
                        mic_bias_dn = 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end

        if (cmd.scan)
        begin
            if (scan_ptr_reg == '0)
            begin
                active_next = '0;
                pwr_dn      = 1'b1;
            end
            else if (cur != '0)
            begin
                active_next = AW'(scan_ptr_reg);
            end
            else
            begin
                scan_ptr_next = scan_ptr_reg - SW'(1);
            end
        end

        // shared counts saturate high and hold at zero
        if (pwr_up && (supply_reg != CNT_MAX))
        begin
            supply_next = supply_reg + CNT_ONE;
        end
        else if (pwr_dn && (supply_reg != '0))
        begin
            supply_next = supply_reg - CNT_ONE;
        end

        if ((pwr_up || mic_bias_up) && (bias_reg != CNT_MAX))
        begin
            bias_next = bias_reg + CNT_ONE;
        end
        else if ((pwr_dn || mic_bias_dn) && (bias_reg != '0))
        begin
            bias_next = bias_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLL_SLOTS; i++)
            begin
                users_reg[i] <= '0;
            end
            active_reg <= '0;
            supply_reg <= '0;
            bias_reg   <= '0;
            mic_reg    <= '0;
        end
        else
        begin
            users_reg  <= users_next;
            active_reg <= active_next;
            supply_reg <= supply_next;
            bias_reg   <= bias_next;
            mic_reg    <= mic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        before_reg   <= before_next;
        status_reg   <= status_next;
        scan_ptr_reg <= scan_ptr_next;
    end

    always_comb
    begin
        mask = '0;
        for (int j = 0; j < 3; j++)
        begin
            if (j < PLL_SLOTS)
            begin
                if (!switch_mode || (j != PLL_SLOTS - 1))
                begin
                    mask[j] = (active_reg == AW'(j + 1));
                end
                if (switch_mode && (j == PLL_SLOTS - 1))
                begin
                    mask[j] = (users_reg[TOP] != '0);
                end
            end
        end
    end

    assign result.status      = status_reg;
    assign result.current_pll = active_reg[1:0];
    assign result.switched    = (before_reg != active_reg);
    assign result.switch_from = before_reg[1:0];
    assign result.switch_to   = active_reg[1:0];
    assign result.pll_on_mask = mask;
    assign result.supply_on   = (supply_reg != '0);
    assign result.ibias_on    = (bias_reg != '0);
    assign result.micbias_on  = (mic_reg != '0);

`include "pll_refcount_arbiter_unit_assert.svh"

    `PRA_ASSERT_NEXT(a_scan_steps_down, cmd.scan && !stat.scan_done, scan_ptr_reg == $past(scan_ptr_reg) - SW'(1), "scan pointer did not step down")
    `PRA_ASSERT_NEXT(a_bad_index_keeps, cmd.exec && !idx_ok && (op_reg == OP_PLL_REQ || op_reg == OP_PLL_REL), active_reg == $past(active_reg) && status_reg == ST_BAD_INDEX, "bad index changed state")

endmodule
